### rtl/core/binary_max_heap_queue_defines.svh
// assertion macros shared by the priority queue rtl
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define HQ_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");

// condition holds in the cycle after the trigger
`define HQ_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

### rtl/core/bmhq_pkg.sv
// types and constants of the priority queue
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  typedef logic signed [KEY_W-1:0] key_t;

  // operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_kind_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // broadcast operation seen by every cell
  typedef struct packed {
    logic ins;
    logic del;
    key_t key;
  } hq_op_t;

  // word a cell hands to its right neighbor
  typedef struct packed {
    logic ge;
    key_t key;
  } hq_link_t;

endpackage

### rtl/core/bmhq_if.sv
// valid/ready channels of the priority queue
`timescale 1ns / 1ps

interface bmhq_in_if
  import bmhq_pkg::*;
;
  logic valid;
  logic ready;
  logic kind;
  key_t key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

interface bmhq_out_if
  import bmhq_pkg::*;
;
  logic               valid;
  logic               ready;
  key_t               removed_key;
  key_t               top_key;
  logic [COUNT_W-1:0] entry_count;
  logic [STAT_W-1:0]  status;

  modport source (output valid, output removed_key, output top_key,
                  output entry_count, output status, input ready);
  modport sink (input valid, input removed_key, input top_key,
                input entry_count, input status, output ready);
endinterface

### rtl/core/bmhq_cell.sv
// one slot of the sorted cell chain
`timescale 1ns / 1ps
module bmhq_cell
  import bmhq_pkg::*;
(
  input  logic     clk,
  input  hq_op_t   op,
  input  logic     occ,
  input  hq_link_t left,
  input  key_t     right_key,
  output hq_link_t link
);

  key_t key_r, key_nxt;
  logic self_ge;

  // occupied slot at least as large as the new key stays put
  assign self_ge   = occ && (key_r >= op.key);
  assign link.ge   = self_ge;
  assign link.key  = key_r;

  // insert shifts right below the insert point, delete shifts left
  always_comb begin
    key_nxt = key_r;
    if (op.ins && !self_ge) begin
      key_nxt = left.ge ? op.key : left.key;
    end else if (op.del) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

### rtl/core/binary_max_heap_queue.sv
// Priority queue top level: a chain of sorted cells, largest key in cell 0.
// A result word is registered in the cycle after its input word is accepted.
// Throughput: one word per cycle unless the output stalls; every cell compares
// against the broadcast key and loads from itself, a neighbor or the new key.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
`timescale 1ns / 1ps
`include "binary_max_heap_queue_defines.svh"
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  bmhq_in_if.sink           in_ch,
  bmhq_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  key_t               removed_r, top_r, top_nxt, removed_nxt;
  logic [COUNT_W-1:0] out_count_r;
  status_t            status_r, status_nxt;

  logic     acc, is_del, full, empty, ins_ok, del_ok;
  hq_op_t   op;
  hq_link_t link [CAPACITY];
  logic     occ  [CAPACITY];
  logic [COUNT_W+CNT_W-1:0] count_ext;

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_del      = (in_ch.kind == OP_DELETE);
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign empty       = (count_r == '0);
  assign ins_ok      = acc && !is_del && !full;
  assign del_ok      = acc && is_del && !empty;

  assign op.ins = ins_ok;
  assign op.del = del_ok;
  assign op.key = in_ch.key;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hq_link_t left;
    key_t     right_key;
    assign occ[i] = (count_r > CNT_W'(i));
    if (i == 0) begin : g_head
      assign left.ge  = 1'b1;
      assign left.key = '0;
    end else begin : g_body
      assign left = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = link[i+1].key;
    end
    bmhq_cell u_cell (
      .clk       (clk),
      .op        (op),
      .occ       (occ[i]),
      .left      (left),
      .right_key (right_key),
      .link      (link[i])
    );
  end

  // count, status and result values
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    top_nxt     = empty ? key_t'(0) : link[0].key;
    if (ins_ok) begin
      count_nxt = count_r + 1'b1;
      top_nxt   = link[0].ge ? link[0].key : in_ch.key;
    end else if (del_ok) begin
      count_nxt   = count_r - 1'b1;
      removed_nxt = link[0].key;
      top_nxt     = (count_r > CNT_W'(1)) ? link[1].key : key_t'(0);
    end else if (is_del) begin
      status_nxt = ST_UNDERFLOW;
    end else begin
      status_nxt = ST_OVERFLOW;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (acc) begin
      removed_r   <= removed_nxt;
      top_r       <= top_nxt;
      out_count_r <= count_ext[COUNT_W-1:0];
      status_r    <= status_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.removed_key = removed_r;
  assign out_ch.top_key     = top_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.status      = status_r;

  `HQ_ASSERT_SAME(a_count_range, 1'b1, count_r <= CNT_W'(CAPACITY))
  `HQ_ASSERT_NEXT(a_insert_count, ins_ok, count_r == $past(count_r) + 1'b1)
  `HQ_ASSERT_SAME(a_head_order, occ[1], link[0].key >= link[1].key)
  `HQ_ASSERT_SAME(a_top_matches, out_valid_r && !empty, top_r == link[0].key)

endmodule

### tb/sv/tb_binary_max_heap_queue.sv
// self-checking testbench for the binary max-heap priority queue
`timescale 1ns / 1ps
module tb_binary_max_heap_queue;
  import bmhq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RANDOM_OPS  = 1150;
  localparam int HOLD_CYCLES = 90;
  localparam int STALL_LIMIT = 600;
  localparam int CALM_LO     = 500;
  localparam int CALM_HI     = 700;

  typedef struct {
    op_kind_t kind;
    key_t     key;
  } heap_op_t;

  typedef struct {
    key_t               removed;
    key_t               top;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } heap_result_t;

  logic clk;
  logic rst_n;

  bmhq_in_if  in_ch ();
  bmhq_out_if out_ch ();

  binary_max_heap_queue #(.CAPACITY(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // operations still to be offered, and results the queue still owes
  heap_op_t     op_backlog[$];
  heap_result_t owed_results[$];

  // shadow heap of the stored keys
  key_t heap_keys [DEPTH];
  int   heap_len = 0;
  int   peak_len = 0;

  int op_total        = 0;
  int gen_len         = 0;
  int inputs_taken    = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int stall_cycles    = 0;
  int hold_left       = 0;
  int holds_done      = 0;
  int n_insert        = 0;
  int n_delete        = 0;
  int n_overflow      = 0;
  int n_underflow     = 0;
  logic in_taken      = 1'b0;

  // clock and reset, inputs known from time zero
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = OP_INSERT;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // apply one operation to the shadow heap and return what the queue should report
  function automatic heap_result_t heap_apply(op_kind_t kind, key_t key);
    heap_result_t r;
    int   pos;
    int   up;
    int   lc;
    int   big;
    key_t t;
    r.removed = '0;
    r.status  = ST_OK;
    if (kind == OP_INSERT) begin
      if (heap_len >= DEPTH) begin
        r.status = ST_OVERFLOW;
        n_overflow++;
      end else begin
        n_insert++;
        pos = heap_len;
        heap_keys[pos] = key;
        heap_len++;
        // bubble up past smaller parents
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] >= heap_keys[pos]) break;
          t = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = t;
          pos = up;
        end
      end
    end else begin
      if (heap_len == 0) begin
        r.status = ST_UNDERFLOW;
        n_underflow++;
      end else begin
        n_delete++;
        r.removed = heap_keys[0];
        heap_len--;
        heap_keys[0] = heap_keys[heap_len];
        pos = 0;
        // sink down while not strictly larger than the bigger child
        while (2 * pos + 1 < heap_len) begin
          lc  = 2 * pos + 1;
          big = lc;
          if (lc + 1 < heap_len && heap_keys[lc] < heap_keys[lc + 1]) big = lc + 1;
          if (heap_keys[big] < heap_keys[pos]) break;
          t = heap_keys[big];
          heap_keys[big] = heap_keys[pos];
          heap_keys[pos] = t;
          pos = big;
        end
      end
    end
    if (heap_len > peak_len) peak_len = heap_len;
    r.top   = (heap_len > 0) ? heap_keys[0] : key_t'(0);
    r.count = COUNT_W'(heap_len);
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
             $realtime, results_checked, what, got, want);
  endtask

  task automatic push_op(op_kind_t kind, key_t key);
    heap_op_t op;
    op.kind = kind;
    op.key  = key;
    op_backlog.push_back(op);
    op_total++;
    if (kind == OP_INSERT && gen_len < DEPTH) gen_len++;
    if (kind == OP_DELETE && gen_len > 0) gen_len--;
  endtask

  function automatic key_t pick_key();
    int v;
    case ($urandom_range(0, 9))
      0: pick_key = $urandom_range(0, 1) ? key_t'(32'h7fff_ffff) : key_t'(32'h8000_0000);
      1, 2: begin
        // narrow range so that equal keys are common
        v = $urandom_range(0, 6);
        pick_key = key_t'(v - 3);
      end
      default: pick_key = key_t'($urandom());
    endcase
  endfunction

  // stimulus: directed opening, then biased random fill and drain runs
  initial begin : stimulus
    int seg_len;
    int ins_pct;
    int seg;
    // delete from an empty queue
    push_op(OP_DELETE, key_t'(32'h1234_5678));
    // key extremes, zero, minus one and duplicates
    push_op(OP_INSERT, key_t'(32'h7fff_ffff));
    push_op(OP_INSERT, key_t'(32'h8000_0000));
    push_op(OP_INSERT, key_t'(0));
    push_op(OP_INSERT, key_t'(-1));
    push_op(OP_INSERT, key_t'(1));
    push_op(OP_INSERT, key_t'(32'h7fff_ffff));
    push_op(OP_INSERT, key_t'(32'h8000_0000));
    push_op(OP_DELETE, key_t'(32'hffff_ffff));
    push_op(OP_DELETE, key_t'(0));
    push_op(OP_DELETE, key_t'(32'h8000_0000));
    // fill to capacity with patterns and equal keys
    for (int i = 0; i < 12; i++) begin
      case (i % 4)
        0: push_op(OP_INSERT, key_t'(32'h5555_5555));
        1: push_op(OP_INSERT, key_t'(32'haaaa_aaaa));
        2: push_op(OP_INSERT, key_t'($urandom()));
        default: push_op(OP_INSERT, key_t'(7));
      endcase
    end
    // insert into a full queue, then one delete
    push_op(OP_INSERT, key_t'(32'h7fff_ffff));
    push_op(OP_DELETE, key_t'(0));

    // random runs that lean toward filling or draining
    seg = 0;
    while (op_total < 25 + RANDOM_OPS) begin
      seg_len = $urandom_range(15, 60);
      case (seg % 5)
        0: ins_pct = 85;
        1: ins_pct = 15;
        2: ins_pct = 50;
        3: ins_pct = 70;
        default: ins_pct = 30;
      endcase
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < ins_pct) push_op(OP_INSERT, pick_key());
        else push_op(OP_DELETE, key_t'($urandom()));
      end
      seg++;
    end

    // drain and wrap up
    wait (rst_n);
    @(negedge clk);
    while (inputs_taken != op_total || owed_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (owed_results.size() != 0) begin
      flag_mismatch("results never arrived, owed", owed_results.size(), 0);
    end
    $display("covered %0d operations: %0d inserts, %0d deletes, %0d overflow, %0d underflow",
             op_total, n_insert, n_delete, n_overflow, n_underflow);
    $display("queue peaked at %0d of %0d entries; receiver held off %0d times",
             peak_len, DEPTH, holds_done);
    if (mismatches == 0) begin
      $display("tb_binary_max_heap_queue: done, clean");
    end else begin
      $display("tb_binary_max_heap_queue: done, errors");
    end
    $finish;
  end

  // driver: present the next word once the current one is taken
  always @(negedge clk) begin : drive_words
    heap_op_t nxt;
    logic     fire;
    logic     calm;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      calm = inputs_taken >= CALM_LO && inputs_taken < CALM_HI;
      fire = op_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 24);
      if (fire) begin
        nxt = op_backlog.pop_front();
        in_ch.kind <= nxt.kind;
        in_ch.key  <= nxt.key;
      end
      in_ch.valid <= fire;
    end
  end

  // receiver: random stalls, two long hold-offs, one calm stretch
  always @(negedge clk) begin : sink_ready
    logic calm;
    if (rst_n) begin
      calm = results_checked >= CALM_LO && results_checked < CALM_HI;
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if ((holds_done == 0 && results_checked >= 300) ||
                   (holds_done == 1 && results_checked >= 850)) begin
        hold_left    <= HOLD_CYCLES - 1;
        holds_done   <= holds_done + 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(0, 99) >= 24;
      end
    end
  end

  // predict on each accepted operation, check each accepted result word
  always @(posedge clk) begin : score_words
    heap_result_t want;
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        owed_results.push_back(heap_apply(op_kind_t'(in_ch.kind), in_ch.key));
        inputs_taken <= inputs_taken + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked <= results_checked + 1;
        if (owed_results.size() == 0) begin
          flag_mismatch("word with nothing owed, count", out_ch.entry_count, 0);
        end else begin
          want = owed_results.pop_front();
          if (out_ch.removed_key !== want.removed)
            flag_mismatch("removed_key", out_ch.removed_key, want.removed);
          if (out_ch.top_key !== want.top)
            flag_mismatch("top_key", out_ch.top_key, want.top);
          if (out_ch.entry_count !== want.count)
            flag_mismatch("entry_count", out_ch.entry_count, want.count);
          if (out_ch.status !== want.status)
            flag_mismatch("status", out_ch.status, want.status);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("tb_binary_max_heap_queue: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
